/* design/srsw_pkg.sv */
// Shared types, constants and helpers for the selective-repeat sender window.
`timescale 1ns / 1ps

package srsw_pkg;

  localparam int MAX_WINDOW = 8;
  localparam int SEQ_WIDTH  = 16;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int WSZ_W      = 4;
  localparam int SB_W       = 5;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_SEQ_BITS    = 1'b1;

  localparam logic [WSZ_W-1:0] WINDOW_SIZE_RST = WSZ_W'(8);
  localparam logic [SB_W-1:0]  SEQ_BITS_RST    = SB_W'(8);

  typedef enum logic [1:0] {
    OP_SEND,
    OP_ACK,
    OP_TIMEOUT,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    ACT_REFUSED,
    ACT_SENT,
    ACT_BAD_CKSUM,
    ACT_ACK_OUTSIDE,
    ACT_ACK_MARKED,
    ACT_TIMER_STOP,
    ACT_RETRANSMIT,
    ACT_TO_IGNORED
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_HEAD,
    ST_RD_TAIL,
    ST_SEARCH,
    ST_HIT,
    ST_MISS,
    ST_SLIDE
  } state_e;

  typedef struct packed {
    logic                 we;
    logic [SLOT_W-1:0]    waddr;
    logic [SEQ_WIDTH-1:0] wdata;
    logic                 re;
    logic [SLOT_W-1:0]    raddr;
  } mem_req_t;

  typedef struct packed {
    act_e                 action;
    logic [SEQ_WIDTH-1:0] seq;
    logic [SLOT_W-1:0]    slot;
    logic [CNT_W-1:0]     in_flight;
    logic                 full;
    logic                 last;
  } result_t;

  // Clamp the ring size register to 1..MAX_WINDOW
  function automatic logic [CNT_W-1:0] eff_size(input logic [WSZ_W-1:0] ws);
    logic [CNT_W-1:0] r;
    if (ws == '0) begin
      r = CNT_W'(1);
    end else if (int'(ws) > MAX_WINDOW) begin
      r = CNT_W'(MAX_WINDOW);
    end else begin
      r = CNT_W'(ws);
    end
    return r;
  endfunction

  // Clamp the width register to 1..SEQ_WIDTH and build the low-bit mask
  function automatic logic [SEQ_WIDTH-1:0] seq_mask(input logic [SB_W-1:0] sb);
    logic [SB_W-1:0]      b;
    logic [SEQ_WIDTH-1:0] m;
    if (sb == '0) begin
      b = SB_W'(1);
    end else if (int'(sb) > SEQ_WIDTH) begin
      b = SB_W'(SEQ_WIDTH);
    end else begin
      b = sb;
    end
    for (int i = 0; i < SEQ_WIDTH; i++) begin
      m[i] = (SB_W'(i) < b);
    end
    return m;
  endfunction

endpackage

/* design/srsw_mem.sv */
// Sequence-number store of the ring slots: one write port, one registered read port.
`timescale 1ns / 1ps

module srsw_mem
  import srsw_pkg::*;
(
  input  logic                 clk_i,
  input  mem_req_t             req_i,
  output logic [SEQ_WIDTH-1:0] rdata_o
);

  logic [SEQ_WIDTH-1:0] mem [MAX_WINDOW];
  logic [SEQ_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/srsw_ctrl.sv */
// Window sequencer: ring state, acked marks, lookup search and slide.
`timescale 1ns / 1ps

module srsw_ctrl
  import srsw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  input  logic                 checksum_ok_i,
  input  logic [SEQ_WIDTH-1:0] event_seq_i,
  input  logic                 out_free_i,
  output logic                 emit_o,
  output result_t              res_o,
  input  logic [CNT_W-1:0]     size_i,
  input  logic [SEQ_WIDTH-1:0] mask_i,
  input  logic                 cfg_clr_i,
  input  logic [SEQ_WIDTH-1:0] clr_mask_i,
  output mem_req_t             mem_req_o,
  input  logic [SEQ_WIDTH-1:0] mem_rdata_i
);

  localparam int SUM_W = CNT_W + 1;

  state_e               state_q, state_d;
  op_e                  op_q;
  logic                 ok_q;
  logic [SEQ_WIDTH-1:0] seq_q;
  logic [SLOT_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [SEQ_WIDTH-1:0] next_q, next_d;
  logic [MAX_WINDOW-1:0] acked_q, acked_d;
  logic [SEQ_WIDTH-1:0] hs_q, hs_d;
  logic [SLOT_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]     idx_q, idx_d;

  logic [SLOT_W-1:0]    send_slot, tail_slot, head_nxt, ptr_nxt;
  logic                 is_full, in_range, match, slide_after_mark, slide_more;
  logic                 accept;
  logic [SEQ_WIDTH-1:0] sq_masked;

  function automatic logic [SLOT_W-1:0] ring_wrap(input logic [SUM_W-1:0] sum,
                                                  input logic [CNT_W-1:0] size);
    logic [SUM_W-1:0] s_ext;
    logic [SUM_W-1:0] r;
    s_ext = SUM_W'(size);
    r = (sum >= s_ext) ? sum - s_ext : sum;
    return SLOT_W'(r);
  endfunction

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  assign send_slot = ring_wrap(SUM_W'(head_q) + SUM_W'(count_q), size_i);
  assign tail_slot = ring_wrap(SUM_W'(head_q) + SUM_W'(count_q) - SUM_W'(1), size_i);
  assign head_nxt  = ring_wrap(SUM_W'(head_q) + SUM_W'(1), size_i);
  assign ptr_nxt   = ring_wrap(SUM_W'(ptr_q) + SUM_W'(1), size_i);
  assign is_full   = (count_q >= size_i);
  assign sq_masked = next_q & mask_i;

  // Read data holds the tail number in ST_RD_TAIL, the probed entry in ST_SEARCH
  always_comb begin
    if (hs_q <= mem_rdata_i) begin
      in_range = (hs_q <= seq_q) && (seq_q <= mem_rdata_i);
    end else begin
      in_range = (hs_q <= seq_q) || (seq_q <= mem_rdata_i);
    end
  end

  assign match            = (mem_rdata_i == seq_q);
  assign slide_after_mark = acked_q[head_q] || (ptr_q == head_q);
  assign slide_more       = (count_q != CNT_W'(1)) && acked_q[head_nxt];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (op_q)
          OP_SEND: begin
            if (out_free_i) state_d = ST_IDLE;
          end
          OP_ACK: begin
            if (!ok_q) begin
              if (out_free_i) state_d = ST_IDLE;
            end else if (count_q == '0) begin
              state_d = ST_MISS;
            end else begin
              state_d = ST_RD_HEAD;
            end
          end
          OP_TIMEOUT: begin
            state_d = (count_q == '0) ? ST_MISS : ST_RD_HEAD;
          end
          OP_NONE: state_d = ST_IDLE;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_RD_HEAD: state_d = ST_RD_TAIL;
      ST_RD_TAIL: state_d = in_range ? ST_SEARCH : ST_MISS;
      ST_SEARCH: begin
        priority if (match) begin
          state_d = ST_HIT;
        end else if (idx_q + CNT_W'(1) == count_q) begin
          state_d = ST_MISS;
        end
      end
      ST_HIT: begin
        if (out_free_i) begin
          state_d = (op_q == OP_ACK && slide_after_mark) ? ST_SLIDE : ST_IDLE;
        end
      end
      ST_MISS: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      ST_SLIDE: begin
        if (out_free_i && !slide_more) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    next_d     = next_q;
    acked_d    = acked_q;
    hs_d       = hs_q;
    ptr_d      = ptr_q;
    idx_d      = idx_q;
    mem_req_o  = '0;
    emit_o     = 1'b0;
    res_o      = '0;
    res_o.last = 1'b1;

    unique case (state_q)
      ST_IDLE: ;
      ST_DISPATCH: begin
        if (op_q == OP_SEND && out_free_i) begin
          emit_o = 1'b1;
          if (is_full) begin
            res_o.action = ACT_REFUSED;
            res_o.seq    = next_q;
          end else begin
            mem_req_o.we     = 1'b1;
            mem_req_o.waddr  = send_slot;
            mem_req_o.wdata  = sq_masked;
            acked_d[send_slot] = 1'b0;
            next_d  = (sq_masked + SEQ_WIDTH'(1)) & mask_i;
            count_d = count_q + CNT_W'(1);
            res_o.action = ACT_SENT;
            res_o.seq    = sq_masked;
            res_o.slot   = send_slot;
          end
        end else if (op_q == OP_ACK && !ok_q) begin
          emit_o       = out_free_i;
          res_o.action = ACT_BAD_CKSUM;
          res_o.seq    = seq_q;
        end else if ((op_q == OP_ACK || op_q == OP_TIMEOUT) && count_q != '0) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = head_q;
        end
      end
      ST_RD_HEAD: begin
        hs_d            = mem_rdata_i;
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = tail_slot;
      end
      ST_RD_TAIL: begin
        if (in_range) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = head_q;
          ptr_d           = head_q;
          idx_d           = '0;
        end
      end
      ST_SEARCH: begin
        // Advance the probe until a match or the tail is reached
        if (!match && idx_q + CNT_W'(1) != count_q) begin
          ptr_d           = ptr_nxt;
          idx_d           = idx_q + CNT_W'(1);
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ptr_nxt;
        end
      end
      ST_HIT: begin
        emit_o     = out_free_i;
        res_o.seq  = seq_q;
        res_o.slot = ptr_q;
        if (op_q == OP_ACK) begin
          res_o.action = ACT_ACK_MARKED;
          res_o.last   = !slide_after_mark;
          if (out_free_i) begin
            acked_d[ptr_q] = 1'b1;
            if (slide_after_mark) begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = head_q;
            end
          end
        end else begin
          res_o.action = ACT_RETRANSMIT;
        end
      end
      ST_MISS: begin
        emit_o       = out_free_i;
        res_o.action = (op_q == OP_ACK) ? ACT_ACK_OUTSIDE : ACT_TO_IGNORED;
        res_o.seq    = seq_q;
      end
      ST_SLIDE: begin
        emit_o       = out_free_i;
        res_o.action = ACT_TIMER_STOP;
        res_o.seq    = mem_rdata_i;
        res_o.slot   = head_q;
        res_o.last   = !slide_more;
        if (out_free_i) begin
          head_d  = head_nxt;
          count_d = count_q - CNT_W'(1);
          if (slide_more) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = head_nxt;
          end
        end
      end
      default: ;
    endcase

    res_o.in_flight = count_d;
    res_o.full      = (count_d >= size_i);

    // A register write empties the window
    if (cfg_clr_i) begin
      head_d  = '0;
      count_d = '0;
      acked_d = '0;
      next_d  = next_q & clr_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      next_q  <= '0;
      acked_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      next_q  <= next_d;
      acked_q <= acked_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      ok_q  <= checksum_ok_i;
      seq_q <= event_seq_i;
    end
    hs_q  <= hs_d;
    ptr_q <= ptr_d;
    idx_q <= idx_d;
  end

endmodule

/* design/selective_repeat_sender_window.sv */
// Top level of the selective-repeat sender window: config registers, sequencer, result register.
//
//   channel  direction  handshake                       payload
//   in       input      in_valid_i / in_stall_o         operation_i, checksum_ok_i, event_seq_i
//   out      output     out_valid_o / out_stall_i       action_o, seq_out_o, slot_out_o,
//                                                       in_flight_o, window_full_o, last_o
//   cfg      input      psel/penable/pwrite, pready      paddr, pwdata, prdata
//
// Send requests and bad-checksum ACKs are answered from dispatch; empty-window lookups miss.
// Other ACKs and timeouts read the head and tail numbers, then compare entries one a cycle
// through the single read port of the slot store; each released entry adds one result.
// Reset empties the window and sets window_size and seq_bits to 8.
// A stalled result holds in the output register and the sequencer waits behind it.
`timescale 1ns / 1ps

module selective_repeat_sender_window
  import srsw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  input  logic                 checksum_ok_i,
  input  logic [SEQ_WIDTH-1:0] event_seq_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           action_o,
  output logic [SEQ_WIDTH-1:0] seq_out_o,
  output logic [SLOT_W-1:0]    slot_out_o,
  output logic [CNT_W-1:0]     in_flight_o,
  output logic                 window_full_o,
  output logic                 last_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  logic [WSZ_W-1:0]     window_size_q;
  logic [SB_W-1:0]      seq_bits_q;
  logic                 cfg_wr;
  logic [SEQ_WIDTH-1:0] clr_mask;
  logic [CNT_W-1:0]     size;
  logic [SEQ_WIDTH-1:0] mask;

  logic                 out_valid_q;
  result_t              out_q;
  logic                 out_free;
  logic                 emit;
  result_t              res;
  mem_req_t             mem_req;
  logic [SEQ_WIDTH-1:0] mem_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SEQ_BITS) ? PDATA_W'(seq_bits_q) : PDATA_W'(window_size_q);

  assign clr_mask = seq_mask((paddr[2] == REG_SEQ_BITS) ? pwdata[SB_W-1:0] : seq_bits_q);
  assign size     = eff_size(window_size_q);
  assign mask     = seq_mask(seq_bits_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RST;
      seq_bits_q    <= SEQ_BITS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SEQ_BITS) begin
        seq_bits_q <= pwdata[SB_W-1:0];
      end else begin
        window_size_q <= pwdata[WSZ_W-1:0];
      end
    end
  end

  srsw_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  srsw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .checksum_ok_i (checksum_ok_i),
    .event_seq_i   (event_seq_i),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .res_o         (res),
    .size_i        (size),
    .mask_i        (mask),
    .cfg_clr_i     (cfg_wr),
    .clr_mask_i    (clr_mask),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  // Output register: load a new result whenever the old one is gone or leaving
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_q.action;
  assign seq_out_o     = out_q.seq;
  assign slot_out_o    = out_q.slot;
  assign in_flight_o   = out_q.in_flight;
  assign window_full_o = out_q.full;
  assign last_o        = out_q.last;

endmodule

/* tb/tb_selective_repeat_sender_window.sv */
// Self-checking testbench for the selective-repeat sender window: sends, ACKs, timeouts.
`timescale 1ns / 1ps

module tb_selective_repeat_sender_window;
  import srsw_pkg::*;

  localparam int DRAIN_CYCLES = 40;

  // Mirror of the sender window; turns each accepted event into the results it must cause
  class window_tracker;
    logic [SEQ_WIDTH-1:0] seq_tab[MAX_WINDOW];
    bit                   acked_tab[MAX_WINDOW];
    int unsigned          head;
    int unsigned          count;
    logic [SEQ_WIDTH-1:0] next_num;
    logic [WSZ_W-1:0]     ws_reg;
    logic [SB_W-1:0]      sb_reg;
    result_t              due_results[$];
    int                   errors;

    function new();
      foreach (seq_tab[i]) begin
        seq_tab[i] = '0;
        acked_tab[i] = 1'b0;
      end
      head = 0;
      count = 0;
      next_num = '0;
      ws_reg = WINDOW_SIZE_RST;
      sb_reg = SEQ_BITS_RST;
      errors = 0;
    endfunction

    function int unsigned ring_size();
      if (ws_reg == 0) return 1;
      if (ws_reg > MAX_WINDOW) return MAX_WINDOW;
      return ws_reg;
    endfunction

    function logic [SEQ_WIDTH-1:0] width_mask();
      int unsigned b;
      b = sb_reg;
      if (b < 1) b = 1;
      if (b > SEQ_WIDTH) b = SEQ_WIDTH;
      return SEQ_WIDTH'((32'd1 << b) - 1);
    endfunction

    // Any register write empties the window and trims the next number
    function void write_reg(logic idx, logic [PDATA_W-1:0] val);
      if (idx == REG_WINDOW_SIZE) ws_reg = val[WSZ_W-1:0];
      else sb_reg = val[SB_W-1:0];
      head = 0;
      count = 0;
      foreach (acked_tab[i]) acked_tab[i] = 1'b0;
      next_num = next_num & width_mask();
    endfunction

    // Slot holding num, or -1 when num is not in the window
    function int lookup(logic [SEQ_WIDTH-1:0] num);
      int unsigned size;
      int unsigned i;
      int unsigned j;
      logic [SEQ_WIDTH-1:0] hs;
      logic [SEQ_WIDTH-1:0] ts;
      bit hit;
      size = ring_size();
      if (count == 0) return -1;
      hs = seq_tab[head % size];
      ts = seq_tab[(head + count - 1) % size];
      if (hs <= ts) hit = (num >= hs && num <= ts);
      else hit = (num >= hs || num <= ts);
      if (!hit) return -1;
      for (i = 0; i < count && i < size; i++) begin
        j = (head + i) % size;
        if (seq_tab[j] == num) return j;
      end
      return -1;
    endfunction

    function void add(act_e a, logic [SEQ_WIDTH-1:0] s, int unsigned slot);
      result_t r;
      r.action = a;
      r.seq = s;
      r.slot = SLOT_W'(slot);
      r.in_flight = CNT_W'(count);
      r.full = (count >= ring_size());
      r.last = 1'b0;
      due_results.push_back(r);
    endfunction

    function void note_event(op_e op, logic ok, logic [SEQ_WIDTH-1:0] num);
      int unsigned size;
      int unsigned slot;
      int hit;
      logic [SEQ_WIDTH-1:0] sq;
      result_t tail;
      size = ring_size();
      case (op)
        OP_SEND: begin
          if (count >= size) begin
            add(ACT_REFUSED, next_num, 0);
          end else begin
            slot = (head + count) % size;
            sq = next_num & width_mask();
            seq_tab[slot] = sq;
            acked_tab[slot] = 1'b0;
            next_num = (sq + 1'b1) & width_mask();
            count++;
            add(ACT_SENT, sq, slot);
          end
        end
        OP_ACK: begin
          if (!ok) begin
            add(ACT_BAD_CKSUM, num, 0);
          end else begin
            hit = lookup(num);
            if (hit < 0) begin
              add(ACT_ACK_OUTSIDE, num, 0);
            end else begin
              acked_tab[hit] = 1'b1;
              add(ACT_ACK_MARKED, num, hit);
              // slide past every acknowledged head
              while (count > 0 && acked_tab[head % size]) begin
                slot = head % size;
                head = (slot + 1) % size;
                count--;
                add(ACT_TIMER_STOP, seq_tab[slot], slot);
              end
            end
          end
        end
        OP_TIMEOUT: begin
          hit = lookup(num);
          if (hit < 0) add(ACT_TO_IGNORED, num, 0);
          else add(ACT_RETRANSMIT, num, hit);
        end
        default: return;
      endcase
      tail = due_results[due_results.size() - 1];
      tail.last = 1'b1;
      due_results[due_results.size() - 1] = tail;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual action %0d seq %0h",
                 $time, got.action, got.seq);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.action !== want.action) begin
        $display("%0t: action expected %0d actual %0d", $time, want.action, got.action);
        errors++;
      end
      if (got.seq !== want.seq) begin
        $display("%0t: seq_out expected %0h actual %0h", $time, want.seq, got.seq);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $display("%0t: slot_out expected %0d actual %0d", $time, want.slot, got.slot);
        errors++;
      end
      if (got.in_flight !== want.in_flight) begin
        $display("%0t: in_flight expected %0d actual %0d", $time, want.in_flight,
                 got.in_flight);
        errors++;
      end
      if (got.full !== want.full) begin
        $display("%0t: window_full expected %0b actual %0b", $time, want.full, got.full);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function logic [SEQ_WIDTH-1:0] pick_outstanding();
      return seq_tab[(head + $urandom_range(0, count - 1)) % ring_size()];
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           operation;
  logic                 checksum_ok;
  logic [SEQ_WIDTH-1:0] event_seq;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           action;
  logic [SEQ_WIDTH-1:0] seq_out;
  logic [SLOT_W-1:0]    slot_out;
  logic [CNT_W-1:0]     in_flight;
  logic                 window_full;
  logic                 last;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  window_tracker tracker;
  result_t       seen;
  bit            quiet;

  selective_repeat_sender_window dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .checksum_ok_i (checksum_ok),
    .event_seq_i   (event_seq),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .action_o      (action),
    .seq_out_o     (seq_out),
    .slot_out_o    (slot_out),
    .in_flight_o   (in_flight),
    .window_full_o (window_full),
    .last_o        (last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: stall bursts, calm stretches, nothing once the run goes quiet
  always begin
    @(posedge clk);
    if (!quiet) begin
      case ($urandom_range(0, 5))
        0: begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 18)) @(posedge clk);
          out_stall <= 1'b0;
        end
        1: repeat ($urandom_range(20, 60)) @(posedge clk);
        default: ;
      endcase
    end
  end

  // Inputs and outputs only move just after a rising edge, so the falling edge sees
  // the values that the next rising edge will take
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.action = act_e'(action);
      seen.seq = seq_out;
      seen.slot = slot_out;
      seen.in_flight = in_flight;
      seen.full = window_full;
      seen.last = last;
      tracker.check_result(seen);
    end
  end

  task automatic drive_item(op_e op, logic ok, logic [SEQ_WIDTH-1:0] num);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    checksum_ok <= ok;
    event_seq <= num;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    tracker.note_event(op, ok, num);
  endtask

  // Mostly well-formed traffic: sends and events that name an entry in the window
  task automatic random_item();
    int unsigned pick;
    op_e op;
    logic ok;
    logic [SEQ_WIDTH-1:0] num;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_SEND;
    else if (pick < 78) op = OP_ACK;
    else if (pick < 96) op = OP_TIMEOUT;
    else op = OP_NONE;
    ok = ($urandom_range(0, 9) != 0);
    if (tracker.count > 0 && $urandom_range(0, 3) != 0) begin
      num = tracker.pick_outstanding();
    end else begin
      case ($urandom_range(0, 2))
        0: num = SEQ_WIDTH'($urandom);
        1: num = SEQ_WIDTH'($urandom) & tracker.width_mask();
        default: num = (tracker.next_num + SEQ_WIDTH'($urandom_range(0, 3)))
                       & tracker.width_mask();
      endcase
    end
    drive_item(op, ok, num);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic idx, logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.write_reg(idx, val);
  endtask

  task automatic reconfigure(int unsigned ws, int unsigned sb);
    logic [PDATA_W-1:0] junk;
    wait_drain();
    // upper data bits are don't-care; vary them now and then
    junk = ($urandom_range(0, 1) == 0) ? '0 : PDATA_W'($urandom);
    apb_write(REG_WINDOW_SIZE, (junk & ~PDATA_W'(15)) | PDATA_W'(ws));
    apb_write(REG_SEQ_BITS, (junk & ~PDATA_W'(31)) | PDATA_W'(sb));
  endtask

  initial begin
    int unsigned ws_list[10] = '{1, 8, 3, 0, 15, 5, 8, 2, 7, 4};
    int unsigned sb_list[10] = '{1, 16, 2, 0, 31, 3, 1, 16, 4, 8};
    tracker = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    operation = OP_SEND;
    checksum_ok = 1'b0;
    event_seq = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty window: every lookup misses
    drive_item(OP_ACK, 1'b1, 16'h0000);
    drive_item(OP_TIMEOUT, 1'b0, 16'hFFFF);
    drive_item(OP_NONE, 1'b1, 16'hA5A5);
    drive_item(OP_ACK, 1'b0, 16'hFFFF);
    // fill the window, then one send too many
    for (int i = 0; i < MAX_WINDOW; i++) drive_item(OP_SEND, 1'b0, 16'h0000);
    drive_item(OP_SEND, 1'b1, 16'h0000);
    // bits above the sequence width put the number outside, then a timeout hit and a bad-checksum ACK
    drive_item(OP_ACK, 1'b1, 16'h0105);
    drive_item(OP_TIMEOUT, 1'b1, 16'h0003);
    drive_item(OP_ACK, 1'b0, 16'h0003);
    // mark every entry but the head, once twice, then release all eight at once
    for (int i = MAX_WINDOW - 1; i > 0; i--) drive_item(OP_ACK, 1'b1, SEQ_WIDTH'(i));
    drive_item(OP_ACK, 1'b1, 16'h0001);
    drive_item(OP_ACK, 1'b1, 16'h0000);

    for (int p = 0; p < 10; p++) begin
      reconfigure(ws_list[p], sb_list[p]);
      if (p == 9) quiet = 1'b1;
      for (int k = 0; k < 35; k++) begin
        random_item();
        if (p == 4 && k == 17) wait_drain();
      end
    end
    wait_drain();

    if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
      $display("tb_selective_repeat_sender_window passed");
    end else begin
      $display("tb_selective_repeat_sender_window failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_selective_repeat_sender_window failed");
    $finish;
  end

endmodule
